>>> hw/rtl/cru_pkg.sv
`default_nettype none
package cru_pkg;

    localparam int CRU_COORD_W     = 16;
    // Window points and phantoms need two guard bits above a coordinate.
    localparam int CRU_POINT_W     = CRU_COORD_W + 2;
    localparam int CRU_WEIGHT_W    = 9;
    localparam int CRU_FRAC_BITS   = 7;
    localparam int CRU_QUEUE_DEPTH = 2;

    typedef logic signed [CRU_POINT_W-1:0] t_point;

    typedef struct packed {
        logic signed [CRU_COORD_W-1:0] x_in;
        logic signed [CRU_COORD_W-1:0] y_in;
        logic                          last_point;
    } t_in_beat;

    typedef struct packed {
        logic signed [CRU_COORD_W-1:0] x_out;
        logic signed [CRU_COORD_W-1:0] y_out;
        logic                          last_of_run;
        logic                          end_of_curve;
    } t_out_beat;

    // One segment: four control points per axis, oldest in element 0.
    typedef struct packed {
        t_point [3:0] px;
        t_point [3:0] py;
        logic         run_last;
        logic         curve_end;
    } t_job;

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_FULL
    } t_seen;

    // Spline weights in 1/128 units, one row per sample phase t = 0, 1/4, 1/2, 3/4.
    localparam logic signed [CRU_WEIGHT_W-1:0] CRU_WEIGHT [4][4] = '{
        '{ 9'sd0,   9'sd128, 9'sd0,   9'sd0  },
        '{-9'sd9,   9'sd111, 9'sd29, -9'sd3  },
        '{-9'sd8,   9'sd72,  9'sd72, -9'sd8  },
        '{-9'sd3,   9'sd29,  9'sd111, -9'sd9 }
    };

endpackage
`default_nettype wire

>>> hw/rtl/catmull_rom_upsample_by_four_core.sv
`default_nettype none
// Catmull-Rom upsampler: takes curve points and returns four spline samples per segment.
// Input channel: i_in_valid / o_in_stall carry one point a beat, with last_point
// closing a curve. Output channel: o_out_valid / i_out_stall carry one sample a beat;
// last_of_run marks the final sample caused by a point, end_of_curve the final sample
// of the whole curve.
// The first two points of a curve produce nothing unless one of them closes it, which
// gives one end segment of four samples; each later point produces four samples, and a
// closing point adds four more for the end segment.
// Throughput: one sample per cycle while the queue holds a segment and the receiver does
// not stall, set by the single shared multiply and round unit in the back end; a closing
// point with two segments holds intake while its second segment waits to be queued.
// Each segment passes the queue, the product registers and the output register in turn.
// The front end fills a segment queue of P_QUEUE_DEPTH entries, and keeps taking
// points while the back end or the receiver is stalled until that queue is full.
// When the receiver stalls, the output register holds its sample unchanged.
// Synchronous active-low reset empties the queue and pipeline and starts a new curve.
module catmull_rom_upsample_by_four_core #(
    parameter int P_QUEUE_DEPTH = cru_pkg::CRU_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cru_pkg::t_in_beat i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cru_pkg::t_out_beat     o_out_data
);
    import cru_pkg::*;

    logic push, pop, q_full, q_empty;
    t_job push_job, head_job;

    cru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_q_full   (q_full)
    );

    cru_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty)
    );

    cru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> hw/rtl/cru_front.sv
`default_nettype none
module cru_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cru_pkg::t_in_beat i_in_data,
    output logic                  o_push,
    output cru_pkg::t_job         o_job,
    input  wire logic             i_q_full
);
    import cru_pkg::*;

    t_seen  r_seen, n_seen;
    t_point r_wx [3];
    t_point r_wy [3];
    t_point n_wx [3];
    t_point n_wy [3];
    logic   r_pend_valid, n_pend_valid;
    t_job   r_pend, n_pend;

    t_point x, y;
    logic   accept;
    logic   has_job, two_jobs;
    t_job   job1, job2;

    assign x = {{2{i_in_data.x_in[CRU_COORD_W-1]}}, i_in_data.x_in};
    assign y = {{2{i_in_data.y_in[CRU_COORD_W-1]}}, i_in_data.y_in};

    // A second segment from a closing point is parked and blocks intake until it is pushed.
    assign o_in_stall = r_pend_valid || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_seen   = r_seen;
        n_wx     = r_wx;
        n_wy     = r_wy;
        has_job  = 1'b0;
        two_jobs = 1'b0;
        job1     = '0;
        job2     = '0;
        unique case (r_seen)
            SEEN_NONE: begin
                if (i_in_data.last_point) begin
                    has_job   = 1'b1;
                    job1.px   = {x, x, x, x};
                    job1.py   = {y, y, y, y};
                    job1.run_last  = 1'b1;
                    job1.curve_end = 1'b1;
                end else begin
                    n_wx[2] = x;
                    n_wy[2] = y;
                    n_seen  = SEEN_ONE;
                end
            end
            SEEN_ONE: begin
                n_wx[0] = (r_wx[2] <<< 1) - x;
                n_wy[0] = (r_wy[2] <<< 1) - y;
                n_wx[1] = r_wx[2];
                n_wy[1] = r_wy[2];
                n_wx[2] = x;
                n_wy[2] = y;
                if (i_in_data.last_point) begin
                    has_job = 1'b1;
                    job1.px = {(x <<< 1) - r_wx[2], x, r_wx[2], n_wx[0]};
                    job1.py = {(y <<< 1) - r_wy[2], y, r_wy[2], n_wy[0]};
                    job1.run_last  = 1'b1;
                    job1.curve_end = 1'b1;
                end else begin
                    n_seen = SEEN_FULL;
                end
            end
            SEEN_FULL: begin
                has_job = 1'b1;
                job1.px = {x, r_wx[2], r_wx[1], r_wx[0]};
                job1.py = {y, r_wy[2], r_wy[1], r_wy[0]};
                job1.run_last  = !i_in_data.last_point;
                job1.curve_end = 1'b0;
                two_jobs = i_in_data.last_point;
                job2.px = {(x <<< 1) - r_wx[2], x, r_wx[2], r_wx[1]};
                job2.py = {(y <<< 1) - r_wy[2], y, r_wy[2], r_wy[1]};
                job2.run_last  = 1'b1;
                job2.curve_end = 1'b1;
                n_wx[0] = r_wx[1];
                n_wy[0] = r_wy[1];
                n_wx[1] = r_wx[2];
                n_wy[1] = r_wy[2];
                n_wx[2] = x;
                n_wy[2] = y;
            end
            default: begin
                n_seen = SEEN_NONE;
            end
        endcase
        if (i_in_data.last_point) begin
            n_seen = SEEN_NONE;
            for (int i = 0; i < 3; i++) begin
                n_wx[i] = '0;
                n_wy[i] = '0;
            end
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_push       = 1'b0;
        o_job        = job1;
        if (r_pend_valid) begin
            o_job = r_pend;
            if (!i_q_full) begin
                o_push       = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (accept) begin
            o_push = has_job;
            if (two_jobs) begin
                n_pend_valid = 1'b1;
                n_pend       = job2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= SEEN_NONE;
            r_pend_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else begin
            r_pend_valid <= n_pend_valid;
            if (accept) begin
                r_seen <= n_seen;
                r_wx   <= n_wx;
                r_wy   <= n_wy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule
`default_nettype wire

>>> hw/rtl/cru_queue.sv
`default_nettype none
module cru_queue #(
    parameter int P_DEPTH = cru_pkg::CRU_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cru_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output cru_pkg::t_job      o_head,
    output logic               o_empty
);
    import cru_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/cru_back.sv
`default_nettype none
module cru_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cru_pkg::t_job i_head,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cru_pkg::t_out_beat o_out_data
);
    import cru_pkg::*;

    localparam int PROD_W = CRU_POINT_W + CRU_WEIGHT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - CRU_FRAC_BITS;
    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W - CRU_COORD_W + 1){1'b0}}, {(CRU_COORD_W - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO =
        {{(RND_W - CRU_COORD_W + 1){1'b1}}, {(CRU_COORD_W - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (CRU_FRAC_BITS - 1));

    logic [1:0]               r_phase;
    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_px [4];
    logic signed [PROD_W-1:0] r_a_py [4];
    logic                     r_a_run_last, r_a_curve_end;
    logic                     r_out_valid;
    t_out_beat                r_out;

    logic                     adv_out, a_ready, issue, final_phase;
    logic signed [PROD_W-1:0] prod_x [4];
    logic signed [PROD_W-1:0] prod_y [4];
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [RND_W-1:0]  rnd_x, rnd_y;
    logic signed [RND_W-1:0]  sat_x, sat_y;

    assign adv_out     = !r_out_valid || !i_out_stall;
    assign a_ready     = !r_a_valid || adv_out;
    assign issue       = !i_q_empty && a_ready;
    assign final_phase = (r_phase == 2'd3);
    assign o_pop       = issue && final_phase;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod_x[k] = PROD_W'(i_head.px[k]) * PROD_W'(CRU_WEIGHT[r_phase][k]);
            prod_y[k] = PROD_W'(i_head.py[k]) * PROD_W'(CRU_WEIGHT[r_phase][k]);
        end
    end

    // Round half up by adding one half before the arithmetic shift, then clamp.
    always_comb begin
        sum_x = SUM_W'(r_a_px[0]) + SUM_W'(r_a_px[1]) + SUM_W'(r_a_px[2])
              + SUM_W'(r_a_px[3]) + HALF;
        sum_y = SUM_W'(r_a_py[0]) + SUM_W'(r_a_py[1]) + SUM_W'(r_a_py[2])
              + SUM_W'(r_a_py[3]) + HALF;
        rnd_x = RND_W'(sum_x >>> CRU_FRAC_BITS);
        rnd_y = RND_W'(sum_y >>> CRU_FRAC_BITS);
        sat_x = (rnd_x > SAT_HI) ? SAT_HI : ((rnd_x < SAT_LO) ? SAT_LO : rnd_x);
        sat_y = (rnd_y > SAT_HI) ? SAT_HI : ((rnd_y < SAT_LO) ? SAT_LO : rnd_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_phase <= r_phase + 2'd1;
            end
            if (a_ready) begin
                r_a_valid <= issue;
            end
            if (adv_out) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_px        <= prod_x;
            r_a_py        <= prod_y;
            r_a_run_last  <= final_phase && i_head.run_last;
            r_a_curve_end <= final_phase && i_head.curve_end;
        end
        if (adv_out && r_a_valid) begin
            r_out.x_out        <= sat_x[CRU_COORD_W-1:0];
            r_out.y_out        <= sat_y[CRU_COORD_W-1:0];
            r_out.last_of_run  <= r_a_run_last;
            r_out.end_of_curve <= r_a_curve_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/cru_checker.sv
`default_nettype none
module cru_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire cru_pkg::t_out_beat o_out_data
);
    import cru_pkg::*;

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // A stalled sample must stay put until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // The end of a curve is always the end of a run.
    a_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.end_of_curve || o_out_data.last_of_run))
        else $error("end_of_curve without last_of_run");

    // Reset leaves no sample on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A point accepted right after reset cannot produce a sample before the pipeline fills.
    a_min_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 (i_rst_n && in_accept) |=> !o_out_valid)
        else $error("sample appeared too early after first point");

endmodule

bind catmull_rom_upsample_by_four_core cru_checker u_cru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
